// ----- rtl/fnms_pkg.sv -----
// shared constants, types and helpers for the four-neighbour mean stencil
// no dependencies; compiled first
package fnms_pkg;

  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_SAMPLE_BITS    = 32;
  localparam int FW_BITS            = 11;
  localparam int FH_BITS            = 16;
  localparam int COL_BITS           = 10;
  localparam int ROW_BITS           = 16;
  localparam int CFG_IDX_BITS       = 2;
  localparam int CFG_DATA_BITS      = 16;
  localparam int RESET_FRAME_WIDTH  = 1024;
  localparam int RESET_FRAME_HEIGHT = 1024;
  localparam int DIGIT_BITS         = 4;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;

  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_UPPER = 2'd0;  // result for the row above
  localparam slot_t SLOT_LEFT  = 2'd1;  // last row, column to the left
  localparam slot_t SLOT_SELF  = 2'd2;  // final sample of the frame
  localparam slot_t SLOT_DONE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RIGHT,
    S_SLOT,
    S_PREP,
    S_DIV,
    S_FIX,
    S_OUT
  } state_t;

  // one radix-16 step of a divide by three: {remainder, digit} -> {quotient digit, remainder}
  function automatic logic [5:0] div3_digit(input logic [5:0] v);
    logic [13:0] p;
    logic [3:0]  q;
    logic [5:0]  rem;
    p   = {8'd0, v} * 14'd171;
    q   = p[12:9];
    rem = v - ({2'd0, q} + {1'b0, q, 1'b0});
    return {q, rem[1:0]};
  endfunction

endpackage

// ----- rtl/fnms_if.sv -----
// valid/ready stream interfaces for the sample and result channels
// depends on fnms_pkg
interface fnms_in_if #(
  parameter int SAMPLE_BITS = fnms_pkg::DEF_SAMPLE_BITS
);
  import fnms_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fnms_out_if #(
  parameter int SAMPLE_BITS = fnms_pkg::DEF_SAMPLE_BITS
);
  import fnms_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic [COL_BITS-1:0]           column;
  logic [ROW_BITS-1:0]           row;
  logic                          frame_last;

  modport source (output valid, output value, output column, output row,
                  output frame_last, input ready);
  modport sink   (input valid, input value, input column, input row,
                  input frame_last, output ready);
endinterface

// ----- rtl/fnms_ram.sv -----
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies
module fnms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/four_neighbour_mean_stencil.sv -----
// four-neighbour mean stencil: top level, two line rams and the result sequencer
// depends on fnms_pkg, fnms_if (fnms_in_if, fnms_out_if) and fnms_ram
//
//   channel   | direction | transaction
//   in_chan   | sink      | one raster sample
//   out_chan  | source    | one averaged sample with column, row and frame_last
//   cfg_*     | write     | frame_width (index 0) or frame_height (index 1)
//
// one sample at a time: accept it and read the line rams, then for each possible
// result an empty slot step if absent; when present, a prepare step, for a
// three-neighbor mean the radix-16 divide by three, for any mean a sign fix,
// then the output step, held while out_chan stalls; then a closing slot step
// returns to idle.
// reset is synchronous and sets only the control and position registers; line rams are
// never cleared, reads are gated by the frame position.
module four_neighbour_mean_stencil #(
  parameter int MAX_WIDTH   = fnms_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = fnms_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fnms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fnms_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  fnms_in_if.sink                            in_chan,
  fnms_out_if.source                         out_chan
);
  import fnms_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = (WW > FW_BITS) ? WW : FW_BITS;
  localparam int MW   = SAMPLE_BITS + 2;
  localparam int NDIG = (MW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PW   = NDIG * DIGIT_BITS;
  localparam int DCW  = $clog2(NDIG);

  // configuration and position
  logic [FW_BITS-1:0]  fw_r;
  logic [FH_BITS-1:0]  fh_r;
  logic [AW-1:0]       col_r;
  logic [ROW_BITS-1:0] row_r;
  logic [CW-1:0]       w_eff;
  logic [ROW_BITS-1:0] h_eff;
  logic [AW-1:0]       c_eff;
  logic [ROW_BITS-1:0] r_eff;
  logic [CW-1:0]       c_inc;
  logic [ROW_BITS:0]   r_inc;
  logic [AW-1:0]       col_next;
  logic [ROW_BITS-1:0] row_next;

  state_t state_r, state_nxt;

  // current sample and its neighborhood
  logic [AW-1:0]          item_c_r;
  logic [ROW_BITS-1:0]    item_r_r;
  logic [SAMPLE_BITS-1:0] x_r;
  logic [SAMPLE_BITS-1:0] old_one_r;
  logic [SAMPLE_BITS-1:0] old_two_r;
  logic [SAMPLE_BITS-1:0] right_r;
  logic [SAMPLE_BITS-1:0] prev_x_r;
  logic [SAMPLE_BITS-1:0] prev2_x_r;
  logic [SAMPLE_BITS-1:0] prev_old_one_r;
  slot_t                  slot_r;

  logic              c_ge1, c_ge2, r_ge1, r_ge2;
  logic [CW-1:0]     c_plus1;
  logic [ROW_BITS:0] r_plus1;
  logic              right_ok, last_col, last_row;

  // selected result
  logic                   use_up, use_rt, use_lf, use_dn;
  logic [SAMPLE_BITS-1:0] nb_up, nb_rt, nb_lf, nb_dn;
  logic                   slot_act;
  logic [SAMPLE_BITS-1:0] slot_center;
  logic [AW-1:0]          slot_col;
  logic [ROW_BITS-1:0]    slot_row;
  logic                   slot_last;
  logic [2:0]             slot_k;
  logic [MW-1:0]          slot_sum;

  logic [MW-1:0]          sum_r;
  logic [2:0]             k_r;
  logic [MW-1:0]          mag;
  logic                   neg_r;
  logic [PW-1:0]          div_shift_r;
  logic [1:0]             div_rem_r;
  logic [DCW-1:0]         div_cnt_r;
  logic [5:0]             div_qr;
  logic [PW-1:0]          fix_val;

  logic [SAMPLE_BITS-1:0] res_value_r;
  logic [AW-1:0]          res_col_r;
  logic [ROW_BITS-1:0]    res_row_r;
  logic                   res_last_r;

  // line rams
  logic                   ram_we;
  logic [AW-1:0]          one_raddr, two_raddr;
  logic [SAMPLE_BITS-1:0] one_rdata, two_rdata;
  logic                   in_ready, out_valid;

  fnms_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_row_one (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_c_r),
    .wdata (x_r),
    .raddr (one_raddr),
    .rdata (one_rdata)
  );

  fnms_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_row_two (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_c_r),
    .wdata (one_rdata),
    .raddr (two_raddr),
    .rdata (two_rdata)
  );

  // effective frame size and raster position
  always_comb begin
    w_eff = CW'(fw_r);
    if (w_eff == '0) begin
      w_eff = CW'(1);
    end else if (w_eff > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end
    h_eff    = (fh_r == '0) ? ROW_BITS'(1) : ROW_BITS'(fh_r);
    c_eff    = (CW'(col_r) >= w_eff) ? '0 : col_r;
    r_eff    = (row_r >= h_eff) ? '0 : row_r;
    c_inc    = CW'(c_eff) + CW'(1);
    r_inc    = {1'b0, r_eff} + (ROW_BITS+1)'(1);
    col_next = c_eff;
    row_next = r_eff;
    if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_BITS-1:0];
    end else begin
      col_next = c_inc[AW-1:0];
    end
  end

  assign c_ge1    = (item_c_r != '0);
  assign c_ge2    = (item_c_r > AW'(1));
  assign r_ge1    = (item_r_r != '0);
  assign r_ge2    = (item_r_r > ROW_BITS'(1));
  assign c_plus1  = CW'(item_c_r) + CW'(1);
  assign r_plus1  = {1'b0, item_r_r} + (ROW_BITS+1)'(1);
  assign right_ok = (c_plus1 < w_eff);
  assign last_col = (c_plus1 == w_eff);
  assign last_row = (r_plus1 == {1'b0, h_eff});

  // neighbor selection for the result in the current slot
  always_comb begin
    use_up      = 1'b0;
    use_rt      = 1'b0;
    use_lf      = 1'b0;
    use_dn      = 1'b0;
    nb_up       = old_two_r;
    nb_rt       = right_r;
    nb_lf       = prev_old_one_r;
    nb_dn       = x_r;
    slot_act    = 1'b0;
    slot_center = old_one_r;
    slot_col    = item_c_r;
    slot_row    = item_r_r;
    slot_last   = 1'b0;
    case (slot_r)
      SLOT_UPPER: begin
        slot_act    = r_ge1;
        use_up      = r_ge2;
        use_rt      = right_ok;
        use_lf      = c_ge1;
        use_dn      = 1'b1;
        slot_center = old_one_r;
        slot_row    = item_r_r - ROW_BITS'(1);
      end
      SLOT_LEFT: begin
        slot_act    = last_row && c_ge1;
        use_up      = r_ge1;
        nb_up       = prev_old_one_r;
        use_rt      = 1'b1;
        nb_rt       = x_r;
        use_lf      = c_ge2;
        nb_lf       = prev2_x_r;
        slot_center = prev_x_r;
        slot_col    = item_c_r - AW'(1);
      end
      SLOT_SELF: begin
        slot_act    = last_row && last_col;
        use_up      = r_ge1;
        nb_up       = old_one_r;
        use_lf      = c_ge1;
        nb_lf       = prev_x_r;
        slot_center = x_r;
        slot_last   = 1'b1;
      end
      default: begin
        slot_act = 1'b0;
      end
    endcase
    slot_k   = 3'(use_up) + 3'(use_rt) + 3'(use_lf) + 3'(use_dn);
    slot_sum = (use_up ? {{2{nb_up[SAMPLE_BITS-1]}}, nb_up} : MW'(0))
             + (use_rt ? {{2{nb_rt[SAMPLE_BITS-1]}}, nb_rt} : MW'(0))
             + (use_lf ? {{2{nb_lf[SAMPLE_BITS-1]}}, nb_lf} : MW'(0))
             + (use_dn ? {{2{nb_dn[SAMPLE_BITS-1]}}, nb_dn} : MW'(0));
  end

  // truncation toward zero: divide the magnitude, restore the sign
  assign mag     = sum_r[MW-1] ? (~sum_r + MW'(1)) : sum_r;
  assign div_qr  = div3_digit({div_rem_r, div_shift_r[PW-1 -: DIGIT_BITS]});
  assign fix_val = neg_r ? (~div_shift_r + PW'(1)) : div_shift_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_RIGHT;
      S_RIGHT: state_nxt = S_SLOT;
      S_SLOT: begin
        if (slot_r == SLOT_DONE) begin
          state_nxt = S_IDLE;
        end else if (slot_act) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (k_r < 3'd2) begin
          state_nxt = S_OUT;
        end else if (k_r == 3'd3) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIX;
        end
      end
      S_DIV: begin
        if (div_cnt_r == DCW'(NDIG - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: state_nxt = S_OUT;
      S_OUT: begin
        if (out_chan.ready) begin
          state_nxt = S_SLOT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and ram control
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ram_we    = 1'b0;
    one_raddr = item_c_r;
    two_raddr = item_c_r;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        one_raddr = c_eff;
        two_raddr = c_eff;
      end
      S_READ: begin
        // old row moves down one store; fetch the right neighbor from the row above
        ram_we    = 1'b1;
        one_raddr = c_plus1[AW-1:0];
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid;
  assign out_chan.value      = res_value_r;
  assign out_chan.column     = COL_BITS'(res_col_r);
  assign out_chan.row        = res_row_r;
  assign out_chan.frame_last = res_last_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fw_r    <= FW_BITS'(RESET_FRAME_WIDTH);
      fh_r    <= FH_BITS'(RESET_FRAME_HEIGHT);
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= SLOT_UPPER;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_chan.valid) begin
        col_r  <= col_next;
        row_r  <= row_next;
        slot_r <= SLOT_UPPER;
      end
      if (state_r == S_SLOT && slot_r != SLOT_DONE) begin
        slot_r <= slot_r + slot_t'(1);
      end
      // a frame width or height write restarts the frame
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            fw_r  <= cfg_wdata[FW_BITS-1:0];
            col_r <= '0;
            row_r <= '0;
          end
          REG_FRAME_HEIGHT: begin
            fh_r  <= cfg_wdata[FH_BITS-1:0];
            col_r <= '0;
            row_r <= '0;
          end
          default: begin
            fw_r <= fw_r;
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          x_r      <= in_chan.sample;
          item_c_r <= c_eff;
          item_r_r <= r_eff;
        end
      end
      S_READ: begin
        old_one_r <= one_rdata;
        old_two_r <= two_rdata;
      end
      S_RIGHT: begin
        right_r <= one_rdata;
      end
      S_SLOT: begin
        if (slot_r == SLOT_DONE) begin
          prev2_x_r      <= prev_x_r;
          prev_x_r       <= x_r;
          prev_old_one_r <= old_one_r;
        end else if (slot_act) begin
          sum_r       <= slot_sum;
          k_r         <= slot_k;
          res_value_r <= slot_center;
          res_col_r   <= slot_col;
          res_row_r   <= slot_row;
          res_last_r  <= slot_last;
        end
      end
      S_PREP: begin
        neg_r     <= sum_r[MW-1];
        div_rem_r <= '0;
        div_cnt_r <= '0;
        if (k_r == 3'd3) begin
          div_shift_r <= PW'(mag);
        end else if (k_r == 3'd2) begin
          div_shift_r <= PW'(mag >> 1);
        end else begin
          div_shift_r <= PW'(mag >> 2);
        end
      end
      S_DIV: begin
        div_shift_r <= {div_shift_r[PW-DIGIT_BITS-1:0], div_qr[5:2]};
        div_rem_r   <= div_qr[1:0];
        div_cnt_r   <= div_cnt_r + DCW'(1);
      end
      S_FIX: begin
        res_value_r <= fix_val[SAMPLE_BITS-1:0];
      end
      default: begin
        res_last_r <= res_last_r;
      end
    endcase
  end

endmodule

// ----- tb/sv/tb.sv -----
// self-checking bench for four_neighbour_mean_stencil: raster frames of Q16.16 samples,
// each result checked against an in-bench line-store predictor
// depends on fnms_pkg, fnms_if (fnms_in_if, fnms_out_if) and the stencil rtl
module tb;
  import fnms_pkg::*;

  localparam int MAX_W      = DEF_MAX_WIDTH;
  localparam int SBITS      = DEF_SAMPLE_BITS;
  localparam int SETTLE     = 40;
  localparam int LIMIT      = 400000;
  localparam int RAND_ITEMS = 295;
  localparam int CALM_TAIL  = 60;
  localparam int SHOW_MAX   = 10;

  // indexes the block decodes to nothing
  localparam cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t REG_SPARE_3 = 2'd3;

  typedef logic signed [SBITS-1:0] sample_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;

  typedef struct {
    sample_t             value;
    logic [COL_BITS-1:0] column;
    logic [ROW_BITS-1:0] row;
    logic                last;
  } mean_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_idx_t  idx;
    cfg_word_t data;
    sample_t   smp;
    bit        typed;
    mean_t     want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_word_t cfg_wdata;

  fnms_in_if  #(.SAMPLE_BITS(SBITS)) in_chan ();
  fnms_out_if #(.SAMPLE_BITS(SBITS)) out_chan ();

  four_neighbour_mean_stencil #(.MAX_WIDTH(MAX_W), .SAMPLE_BITS(SBITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: original values of the two most recent rows, raster position
  sample_t     line_prev2 [MAX_W];
  sample_t     line_prev1 [MAX_W];
  int unsigned col_at;
  int unsigned row_at;
  int unsigned frame_w;
  int unsigned frame_h;
  mean_t       expected_means [$];

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          calm         = 1'b0;
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;

  function automatic void queue_mean(sample_t center, longint acc, int k,
                                     int unsigned c, int unsigned r, bit last);
    mean_t  m;
    longint q;
    // fewer than two neighbors: the sample passes through
    if (k < 2) begin
      m.value = center;
    end else begin
      q = acc / longint'(k);
      m.value = q[SBITS-1:0];
    end
    m.column = c[COL_BITS-1:0];
    m.row    = r[ROW_BITS-1:0];
    m.last   = last;
    expected_means.push_back(m);
  endfunction

  function automatic void predict_means(sample_t x);
    int unsigned w, h, c, r;
    int          k;
    longint      acc;
    sample_t     up2, up1;
    w = (frame_w == 0) ? 1 : (frame_w > MAX_W) ? MAX_W : frame_w;
    h = (frame_h == 0) ? 1 : frame_h;
    if (col_at >= w) col_at = 0;
    if (row_at >= h) row_at = 0;
    c = col_at;
    r = row_at;
    up2 = line_prev2[c];
    up1 = line_prev1[c];
    line_prev2[c] = up1;
    line_prev1[c] = x;
    // the sample above is complete once this one (its lower neighbor) is in
    if (r >= 1) begin
      acc = longint'(x);
      k = 1;
      if (r >= 2) begin
        acc += longint'(up2);
        k++;
      end
      if (c + 1 < w) begin
        acc += longint'(line_prev1[c+1]);
        k++;
      end
      if (c >= 1) begin
        acc += longint'(line_prev2[c-1]);
        k++;
      end
      queue_mean(up1, acc, k, c, r - 1, 1'b0);
    end
    // last row: nothing below, so flush the left neighbor and the frame end
    if (r == h - 1) begin
      if (c >= 1) begin
        acc = longint'(x);
        k = 1;
        if (r >= 1) begin
          acc += longint'(line_prev2[c-1]);
          k++;
        end
        if (c >= 2) begin
          acc += longint'(line_prev1[c-2]);
          k++;
        end
        queue_mean(line_prev1[c-1], acc, k, c - 1, r, 1'b0);
      end
      if (c == w - 1) begin
        acc = 0;
        k = 0;
        if (r >= 1) begin
          acc += longint'(line_prev2[c]);
          k++;
        end
        if (c >= 1) begin
          acc += longint'(line_prev1[c-1]);
          k++;
        end
        queue_mean(x, acc, k, c, r, 1'b1);
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_at = c;
    row_at = r;
  endfunction

  function automatic void note_write(cfg_idx_t idx, cfg_word_t d);
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      if (idx == REG_FRAME_WIDTH) frame_w = 32'(d[FW_BITS-1:0]);
      else frame_h = 32'(d[FH_BITS-1:0]);
      // any geometry write restarts the frame
      col_at = 0;
      row_at = 0;
    end
  endfunction

  function automatic void check_mean();
    mean_t want;
    if (expected_means.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOW_MAX)
        $display("tb: result with nothing pending: value %h col %0d row %0d last %0b",
                 out_chan.value, out_chan.column, out_chan.row, out_chan.frame_last);
    end else begin
      want = expected_means.pop_front();
      if (out_chan.value !== want.value || out_chan.column !== want.column ||
          out_chan.row !== want.row || out_chan.frame_last !== want.last) begin
        fail_count++;
        if (fail_count <= SHOW_MAX)
          $display("tb: mismatch: want %h c%0d r%0d l%0b, got %h c%0d r%0d l%0b",
                   want.value, want.column, want.row, want.last, out_chan.value,
                   out_chan.column, out_chan.row, out_chan.frame_last);
      end
    end
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SBITS-1){1'b1}}};
      1: return {1'b1, {(SBITS-1){1'b0}}};
      2: return sample_t'($urandom_range(0, 15)) - sample_t'(8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic plan_row_t plan_write(cfg_idx_t idx, cfg_word_t d);
    plan_row_t p;
    p.kind  = ROW_WRITE;
    p.idx   = idx;
    p.data  = d;
    p.smp   = '0;
    p.typed = 1'b0;
    return p;
  endfunction

  function automatic plan_row_t plan_sample(sample_t x);
    plan_row_t p;
    p.kind  = ROW_SAMPLE;
    p.idx   = REG_FRAME_WIDTH;
    p.data  = '0;
    p.smp   = x;
    p.typed = 1'b0;
    return p;
  endfunction

  // sample whose single result is written out by hand
  function automatic plan_row_t plan_typed(sample_t x, sample_t v, int c, int r, bit l);
    plan_row_t p;
    p = plan_sample(x);
    p.typed       = 1'b1;
    p.want.value  = v;
    p.want.column = c[COL_BITS-1:0];
    p.want.row    = r[ROW_BITS-1:0];
    p.want.last   = l;
    return p;
  endfunction

  task automatic wait_drained();
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_word_t d);
    in_chan.valid <= 1'b0;
    wait_drained();
    // a sample with no result may still be in flight
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    note_write(idx, d);
  endtask

  task automatic send_sample(sample_t x);
    in_chan.valid  <= 1'b1;
    in_chan.sample <= x;
    do @(posedge clk); while (!in_chan.ready);
    predict_means(x);
  endtask

  task automatic source_gap();
    int n;
    if (!calm && src_idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // result side: check on each transaction, then decide the next ready
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_mean();
    if ($urandom_range(0, 199) == 0) sink_idle_on = ~sink_idle_on;
    if (!calm && sink_idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 19);
    if (stall_left != 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan [$];
    int unsigned sent;
    int unsigned w_new, h_new, ew, eh, frame_len, n;
    bit          paused;
    cfg_word_t   wd;

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_FRAME_WIDTH;
    cfg_wdata      <= '0;
    in_chan.valid  <= 1'b0;
    in_chan.sample <= '0;
    frame_w = RESET_FRAME_WIDTH;
    frame_h = RESET_FRAME_HEIGHT;
    col_at  = 0;
    row_at  = 0;
    sent    = 0;
    paused  = 1'b0;

    plan = {
      // reset geometry: first row of a 1024 x 1024 frame, no results yet
      plan_sample(32'h0001_0000),
      plan_sample(32'hFFFF_0000),
      // single-sample frames pass through, flagged last
      plan_write(REG_FRAME_WIDTH, 16'd1),
      plan_write(REG_FRAME_HEIGHT, 16'd1),
      plan_typed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b1),
      plan_typed(32'h8000_0000, 32'h8000_0000, 0, 0, 1'b1),
      plan_typed(32'h0000_0000, 32'h0000_0000, 0, 0, 1'b1),
      // zero sizes act as one
      plan_write(REG_FRAME_WIDTH, 16'd0),
      plan_write(REG_FRAME_HEIGHT, 16'd0),
      plan_typed(32'hDEAD_BEEF, 32'hDEAD_BEEF, 0, 0, 1'b1),
      // unused indexes change nothing
      plan_write(REG_SPARE_2, 16'hFFFF),
      plan_write(REG_SPARE_3, 16'h0000),
      plan_typed(32'h1234_5678, 32'h1234_5678, 0, 0, 1'b1),
      // 3 x 3: corners, edges and the center, with full-scale values
      plan_write(REG_FRAME_WIDTH, 16'd3),
      plan_write(REG_FRAME_HEIGHT, 16'd3),
      plan_sample(32'hFFFF_FFF9),
      plan_sample(32'h7FFF_FFFF),
      plan_sample(32'hFFFF_FFFF),
      plan_sample(32'h8000_0000),
      plan_sample(32'h0000_0005),
      plan_sample(32'h7FFF_FFFF),
      plan_sample(32'h0000_0003),
      plan_sample(32'h8000_0000),
      plan_sample(32'hFFFF_FFFE),
      // one column: ends have a single neighbor
      plan_write(REG_FRAME_WIDTH, 16'd1),
      plan_write(REG_FRAME_HEIGHT, 16'd3),
      plan_sample(32'h0001_0000),
      plan_sample(32'h8000_0000),
      plan_sample(32'hFFFF_0000),
      // one row
      plan_write(REG_FRAME_WIDTH, 16'd3),
      plan_write(REG_FRAME_HEIGHT, 16'd1),
      plan_sample(32'h0000_0007),
      plan_sample(32'hFFFF_FFFB),
      plan_sample(32'h7FFF_FFFF),
      // oversized width clamps to the line store, tallest frame
      plan_write(REG_FRAME_WIDTH, 16'hFFFF),
      plan_write(REG_FRAME_HEIGHT, 16'hFFFF),
      plan_sample(32'h5555_5555),
      plan_sample(32'hAAAA_AAAA),
      plan_sample(32'h0F0F_F0F0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].smp);
        if (plan[i].typed) begin
          void'(expected_means.pop_back());
          expected_means.push_back(plan[i].want);
        end
        source_gap();
      end
    end

    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w_new = 0;
        1: w_new = $urandom_range(MAX_W, (1 << FW_BITS) - 1);
        2: w_new = $urandom_range(9, 40);
        default: w_new = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: h_new = 0;
        1: h_new = $urandom_range(7, (1 << FH_BITS) - 1);
        default: h_new = $urandom_range(1, 6);
      endcase
      // now and then keep streaming across the old geometry
      if ($urandom_range(0, 7) != 0) begin
        wd = cfg_word_t'(w_new);
        if ($urandom_range(0, 3) == 0)
          wd[CFG_DATA_BITS-1:FW_BITS] = (CFG_DATA_BITS-FW_BITS)'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_FRAME_WIDTH, wd);
          write_reg(REG_FRAME_HEIGHT, cfg_word_t'(h_new));
        end else begin
          write_reg(REG_FRAME_HEIGHT, cfg_word_t'(h_new));
          write_reg(REG_FRAME_WIDTH, wd);
        end
        if ($urandom_range(0, 9) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, cfg_word_t'($urandom));
      end
      ew = (frame_w == 0) ? 1 : (frame_w > MAX_W) ? MAX_W : frame_w;
      eh = (frame_h == 0) ? 1 : frame_h;
      frame_len = (ew * eh > 1000) ? 1000 : ew * eh;
      if (frame_len > 48) n = $urandom_range(8, 40);
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, frame_len);
      else n = frame_len * $urandom_range(1, 2);
      src_idle_on = ($urandom_range(0, 3) != 0);
      repeat (n) begin
        if (sent >= RAND_ITEMS) break;
        send_sample(pick_sample());
        sent++;
        if (sent >= RAND_ITEMS - CALM_TAIL) calm = 1'b1;
        source_gap();
      end
      // once half the items are sent, hold the stream until every pending result is out
      if (!paused && sent >= RAND_ITEMS / 2) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        paused = 1'b1;
      end
    end

    in_chan.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- four_neighbour_mean_stencil.f -----
rtl/fnms_pkg.sv
rtl/fnms_if.sv
rtl/fnms_ram.sv
rtl/four_neighbour_mean_stencil.sv
tb/sv/tb.sv
